// File: hdl/brr_pkg.sv
// Shared types and constants for the BRR ADPCM sample decoder.
package brr_pkg;

  localparam logic [1:0] CMD_HEADER  = 2'd0;
  localparam logic [1:0] CMD_DATA    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [3:0] RANGE_MAX = 4'd12;

  localparam logic [1:0] FILT_NONE = 2'd0;
  localparam logic [1:0] FILT_ONE  = 2'd1;
  localparam logic [1:0] FILT_TWO  = 2'd2;
  localparam logic [1:0] FILT_THREE = 2'd3;

  localparam int SAMPLE_W = 16;

  typedef struct packed {
    logic [3:0] range;
    logic [1:0] filter;
    logic       loop;
    logic       stop;
  } hdr_t;

endpackage

// File: hdl/brr_if.sv
// Stream interfaces for the input commands and the decoded samples.
interface brr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface brr_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [15:0]       sample;
  logic                     block_end;
  logic                     block_loop;
  logic                     last;

  modport source (output valid, output sample, output block_end, output block_loop,
                  output last, input ready);
  modport sink (input valid, input sample, input block_end, input block_loop,
                input last, output ready);
endinterface

// File: hdl/brr_nib_dec.sv
// Combinational decode of one four-bit delta into a sixteen-bit sample.
module brr_nib_dec (
  input  brr_pkg::hdr_t      hdr,
  input  logic [3:0]         nib,
  input  logic signed [15:0] p1_in,
  input  logic signed [15:0] p2_in,
  output logic signed [15:0] sample
);

  localparam logic signed [21:0] SAT_HI = 22'sd32767;
  localparam logic signed [21:0] SAT_LO = -22'sd32768;
  localparam logic signed [21:0] LOW_NEG = -22'sd2048;

  logic signed [21:0] n;
  logic signed [21:0] p1;
  logic signed [21:0] p2;
  logic signed [21:0] scaled;
  logic signed [21:0] pred;
  logic signed [21:0] p1x13;
  logic signed [21:0] d;
  logic signed [21:0] dsat;

  assign n  = {{18{nib[3]}}, nib};
  assign p1 = {{6{p1_in[15]}}, p1_in};
  assign p2 = {{6{p2_in[15]}}, p2_in};
  assign p1x13 = (p1 <<< 3) + (p1 <<< 2) + p1;

  always_comb begin
    if (hdr.range > brr_pkg::RANGE_MAX) begin
      scaled = nib[3] ? LOW_NEG : '0;
    end else begin
      scaled = (n <<< hdr.range) >>> 1;
    end

    case (hdr.filter)
      brr_pkg::FILT_ONE:
        pred = (p1 >>> 1) + ((-p1) >>> 5);
      brr_pkg::FILT_TWO:
        pred = p1 - (p2 >>> 1) + ((-p1 - (p1 >>> 1)) >>> 5) + (p2 >>> 5);
      brr_pkg::FILT_THREE:
        pred = p1 - (p2 >>> 1) + ((-p1x13) >>> 7) + ((p2 + (p2 >>> 1)) >>> 4);
      default:
        pred = '0;
    endcase

    d = scaled + pred;
    if (d > SAT_HI) begin
      dsat = SAT_HI;
    end else if (d < SAT_LO) begin
      dsat = SAT_LO;
    end else begin
      dsat = d;
    end
  end

  // Doubling wraps to 16 bits, so the low bit is always zero.
  assign sample = {dsat[brr_pkg::SAMPLE_W-2:0], 1'b0};

endmodule

// File: hdl/brr_adpcm_sample_decoder.sv
// Top level of the BRR ADPCM sample decoder.
//
//   channel  dir  payload                                   transfer
//   din      in   cmd[1:0], data_byte[7:0]                  valid && ready
//   dout     out  sample[15:0], block_end, block_loop, last valid && ready
//
// A data byte holds the stage register until both nibbles are decoded, one nibble
// per cycle unless dout stalls, through the shared nibble decoder, since the second
// sample predicts from the first. Header, restart and unused commands pass through
// the stage with no result. A sample appears on dout the cycle after its nibble is
// decoded. Reset clears header, history and all valid flags. A stalled dout holds
// the stage; din stays open whenever the stage empties in the same cycle.
module brr_adpcm_sample_decoder (
  input logic        clk,
  input logic        rst,
  brr_in_if.sink     din,
  brr_out_if.source  dout
);

  logic               st_valid;
  logic [1:0]         st_cmd;
  logic [7:0]         st_byte;
  logic               phase;

  brr_pkg::hdr_t      hdr;
  logic signed [15:0] prev;
  logic signed [15:0] older;

  logic               out_valid;
  logic signed [15:0] out_sample;
  logic               out_end;
  logic               out_loop;
  logic               out_last;

  logic               out_free;
  logic               out_load;
  logic               stage_done;
  logic               in_fire;
  logic [3:0]         nib;
  logic signed [15:0] sample_new;

  assign out_free   = !out_valid || dout.ready;
  assign out_load   = st_valid && (st_cmd == brr_pkg::CMD_DATA) && out_free;
  assign stage_done = st_valid && ((st_cmd != brr_pkg::CMD_DATA) || (out_free && phase));
  assign din.ready  = !st_valid || stage_done;
  assign in_fire    = din.valid && din.ready;
  assign nib        = phase ? st_byte[3:0] : st_byte[7:4];

  brr_nib_dec u_dec (
    .hdr    (hdr),
    .nib    (nib),
    .p1_in  (prev),
    .p2_in  (older),
    .sample (sample_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid  <= 1'b0;
      phase     <= 1'b0;
      out_valid <= 1'b0;
      hdr       <= '0;
      prev      <= '0;
      older     <= '0;
    end else begin
      if (in_fire) begin
        st_valid <= 1'b1;
        st_cmd   <= din.cmd;
        st_byte  <= din.data_byte;
      end else if (stage_done) begin
        st_valid <= 1'b0;
      end

      if (out_load) begin
        out_valid  <= 1'b1;
        out_sample <= sample_new;
        out_end    <= hdr.stop;
        out_loop   <= hdr.loop;
        out_last   <= phase;
        phase      <= !phase;
        older      <= prev;
        prev       <= sample_new;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end

      if (st_valid && (st_cmd == brr_pkg::CMD_HEADER)) begin
        hdr <= st_byte;
      end else if (st_valid && (st_cmd == brr_pkg::CMD_RESTART)) begin
        hdr   <= '0;
        prev  <= '0;
        older <= '0;
      end
    end
  end

  assign dout.valid      = out_valid;
  assign dout.sample     = out_sample;
  assign dout.block_end  = out_end;
  assign dout.block_loop = out_loop;
  assign dout.last       = out_last;

  a_first_then_second: assert property (@(posedge clk) disable iff (rst)
    out_load && !phase |=> st_valid && phase && (st_cmd == brr_pkg::CMD_DATA))
    else $error("first sample of a data byte not followed by its second nibble");

  a_low_bit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !out_sample[0])
    else $error("decoded sample has a nonzero low bit");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    st_valid && (st_cmd == brr_pkg::CMD_RESTART) |=> (prev == 16'sd0) && (older == 16'sd0))
    else $error("restart did not clear the sample history");

  a_hold_mid_byte: assert property (@(posedge clk) disable iff (rst)
    st_valid && (st_cmd == brr_pkg::CMD_DATA) && !phase |-> !din.ready)
    else $error("input opened before both nibbles were decoded");

endmodule

// File: dv/brr_adpcm_sample_decoder_tb.sv
// Self-checking testbench for the BRR ADPCM sample decoder: directed table, then random blocks.
`timescale 1ns / 1ps

module brr_adpcm_sample_decoder_tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 380;
  localparam int MAX_GAP = 17;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT_ITEM = 120;
  localparam int PAUSE_AT_ITEM = 260;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_PRINTED = 40;
  localparam int NUM_DIRECTED = 25;

  typedef struct {
    logic signed [15:0] sample;
    logic               stop;
    logic               loop;
    logic               second;
  } sample_rec_t;

  typedef struct {
    logic [1:0]         cmd;
    logic [7:0]         data;
    bit                 typed;
    logic signed [15:0] s0;
    logic signed [15:0] s1;
    logic               stop;
    logic               loop;
  } stim_row_t;

  logic clk;
  logic rst;

  brr_in_if  cmd_bus ();
  brr_out_if sample_bus ();

  brr_adpcm_sample_decoder DUT (
    .clk  (clk),
    .rst  (rst),
    .din  (cmd_bus),
    .dout (sample_bus)
  );

  // Decoder state as the block should hold it.
  brr_pkg::hdr_t      cur_hdr;
  logic signed [15:0] hist1;
  logic signed [15:0] hist2;

  sample_rec_t expected_samples[$];

  int  mismatch_count = 0;
  int  samples_checked = 0;
  int  headers_seen = 0;
  int  data_seen = 0;
  int  restarts_seen = 0;
  int  unused_seen = 0;
  int  items_sent = 0;
  int  cycle_count = 0;
  bit  hold_off_req = 1'b0;

  // Directed rows. Typed rows carry their samples; the rest come from the predictor.
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{brr_pkg::CMD_DATA,    8'h00, 1, 0,      0,      0, 0},
    '{brr_pkg::CMD_DATA,    8'h78, 1, 6,      -8,     0, 0},
    '{brr_pkg::CMD_HEADER,  8'hC0, 0, 0,      0,      0, 0},
    '{brr_pkg::CMD_DATA,    8'h78, 1, 28672,  -32768, 0, 0},
    '{brr_pkg::CMD_HEADER,  8'hD0, 0, 0,      0,      0, 0},
    '{brr_pkg::CMD_DATA,    8'h87, 1, -4096,  0,      0, 0},
    '{brr_pkg::CMD_HEADER,  8'hF3, 0, 0,      0,      0, 0},
    '{brr_pkg::CMD_DATA,    8'hF0, 1, -4096,  0,      1, 1},
    '{CMD_UNUSED,           8'hFF, 0, 0,      0,      0, 0},
    '{brr_pkg::CMD_DATA,    8'h01, 1, 0,      0,      1, 1},
    '{brr_pkg::CMD_HEADER,  8'hC4, 0, 0,      0,      0, 0},
    '{brr_pkg::CMD_DATA,    8'h77, 0, 0,      0,      0, 0},
    '{brr_pkg::CMD_DATA,    8'h77, 0, 0,      0,      0, 0},
    '{brr_pkg::CMD_HEADER,  8'hC8, 0, 0,      0,      0, 0},
    '{brr_pkg::CMD_DATA,    8'h88, 0, 0,      0,      0, 0},
    '{brr_pkg::CMD_DATA,    8'h77, 0, 0,      0,      0, 0},
    '{brr_pkg::CMD_HEADER,  8'hCE, 0, 0,      0,      0, 0},
    '{brr_pkg::CMD_DATA,    8'h7F, 0, 0,      0,      0, 0},
    '{brr_pkg::CMD_DATA,    8'h80, 0, 0,      0,      0, 0},
    '{brr_pkg::CMD_HEADER,  8'h3D, 0, 0,      0,      0, 0},
    '{brr_pkg::CMD_DATA,    8'h5A, 0, 0,      0,      0, 0},
    '{brr_pkg::CMD_RESTART, 8'hFF, 0, 0,      0,      0, 0},
    '{brr_pkg::CMD_DATA,    8'h78, 1, 6,      -8,     0, 0},
    '{brr_pkg::CMD_HEADER,  8'hFF, 0, 0,      0,      0, 0},
    '{brr_pkg::CMD_DATA,    8'h00, 0, 0,      0,      0, 0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d samples outstanding.",
               cycle_count, expected_samples.size());
      $display("brr_adpcm_sample_decoder: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) $display("ERROR at %0t ns: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic logic signed [15:0] predict_nibble(input logic [3:0] nib);
    int n;
    int d;
    int p1;
    int p2;
    logic signed [15:0] s;
    n = int'($signed(nib));
    p1 = hist1;
    p2 = hist2;
    if (cur_hdr.range > brr_pkg::RANGE_MAX) d = (n < 0) ? -2048 : 0;
    else d = (n <<< cur_hdr.range) >>> 1;
    case (cur_hdr.filter)
      brr_pkg::FILT_ONE: d += (p1 >>> 1) + ((-p1) >>> 5);
      brr_pkg::FILT_TWO: d += p1 - (p2 >>> 1) + ((-p1 - (p1 >>> 1)) >>> 5) + (p2 >>> 5);
      brr_pkg::FILT_THREE:
        d += p1 - (p2 >>> 1) + ((-p1 * 13) >>> 7) + ((p2 + (p2 >>> 1)) >>> 4);
      default: ;
    endcase
    if (d > 32767) d = 32767;
    if (d < -32768) d = -32768;
    s = 16'(d * 2);
    hist2 = hist1;
    hist1 = s;
    return s;
  endfunction

  // Advances the predicted state by one command; returns how many samples it yields.
  function automatic int decode_command(input logic [1:0] cmd, input logic [7:0] b,
                                        output sample_rec_t first, output sample_rec_t next);
    first = '{default: '0};
    next = '{default: '0};
    case (cmd)
      brr_pkg::CMD_HEADER: begin
        cur_hdr = brr_pkg::hdr_t'(b);
        headers_seen++;
        return 0;
      end
      brr_pkg::CMD_RESTART: begin
        cur_hdr = '0;
        hist1 = '0;
        hist2 = '0;
        restarts_seen++;
        return 0;
      end
      brr_pkg::CMD_DATA: begin
        first.sample = predict_nibble(b[7:4]);
        first.stop = cur_hdr.stop;
        first.loop = cur_hdr.loop;
        first.second = 1'b0;
        next.sample = predict_nibble(b[3:0]);
        next.stop = cur_hdr.stop;
        next.loop = cur_hdr.loop;
        next.second = 1'b1;
        data_seen++;
        return 2;
      end
      default: begin
        unused_seen++;
        return 0;
      end
    endcase
  endfunction

  task automatic send_row(input stim_row_t row, input int gap);
    sample_rec_t r0;
    sample_rec_t r1;
    int n;
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.cmd <= row.cmd;
    cmd_bus.data_byte <= row.data;
    cmd_bus.valid <= 1'b1;
    do @(posedge clk); while (!(cmd_bus.valid && cmd_bus.ready));
    n = decode_command(row.cmd, row.data, r0, r1);
    if (n == 2) begin
      if (row.typed) begin
        r0.sample = row.s0;
        r1.sample = row.s1;
        r0.stop = row.stop;
        r1.stop = row.stop;
        r0.loop = row.loop;
        r1.loop = row.loop;
      end
      expected_samples.push_back(r0);
      expected_samples.push_back(r1);
    end
  endtask

  // Stretches without gaps come every fourth group of forty items and during the hold.
  function automatic int sender_gap();
    if (hold_off_req || (items_sent / 40) % 4 == 3) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  task automatic send_random(input logic [1:0] cmd, input logic [7:0] b);
    stim_row_t row;
    row = '{cmd, b, 0, 0, 0, 0, 0};
    send_row(row, sender_gap());
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  function automatic logic [7:0] random_header();
    logic [7:0] h;
    h = 8'($urandom_range(0, 255));
    // Keep most blocks in the shifting ranges; the clipped ones still turn up.
    if (h[7:4] > brr_pkg::RANGE_MAX && $urandom_range(0, 3) != 0)
      h[7:4] = 4'($urandom_range(0, 12));
    return h;
  endfunction

  // Stimulus side.
  initial begin
    int pick;
    int nbytes;
    bit hold_started;
    bit pause_done;
    hold_started = 1'b0;
    pause_done = 1'b0;
    rst = 1'b1;
    cmd_bus.valid = 1'b0;
    cmd_bus.cmd = brr_pkg::CMD_HEADER;
    cmd_bus.data_byte = 8'h00;
    sample_bus.ready = 1'b0;
    cur_hdr = '0;
    hist1 = '0;
    hist2 = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) send_row(directed_rows[i], $urandom_range(0, MAX_GAP));

    while (items_sent < RANDOM_ITEMS) begin
      if (!hold_started && items_sent >= HOLD_AT_ITEM) begin
        hold_off_req = 1'b1;
        hold_started = 1'b1;
      end
      if (!pause_done && items_sent >= PAUSE_AT_ITEM) begin
        cmd_bus.valid <= 1'b0;
        @(posedge clk);
        while (expected_samples.size() != 0) @(posedge clk);
        pause_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_random(brr_pkg::CMD_RESTART, 8'($urandom_range(0, 255)));
      end else if (pick < 7) begin
        send_random(CMD_UNUSED, 8'($urandom_range(0, 255)));
      end else if (pick < 12) begin
        send_random(brr_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
      end else begin
        send_random(brr_pkg::CMD_HEADER, random_header());
        nbytes = $urandom_range(1, 8);
        repeat (nbytes) send_random(brr_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
      end
    end
    cmd_bus.valid <= 1'b0;

    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d headers, %0d data bytes, %0d restarts and %0d unused codes.",
             headers_seen, data_seen, restarts_seen, unused_seen);
    $display("Checked %0d decoded samples, %0d errors, including a long output stall.",
             samples_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("brr_adpcm_sample_decoder: match");
    end else begin
      $display("brr_adpcm_sample_decoder: mismatch");
    end
    $finish;
  end

  // Sample side: random stalls, one long hold-off on request, field-by-field compare.
  initial begin
    sample_rec_t want;
    int stall;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        sample_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        stall = ((samples_checked / 50) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
        if (stall > 0) begin
          sample_bus.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      sample_bus.ready <= 1'b1;
      do @(posedge clk); while (!(sample_bus.valid && sample_bus.ready));
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("sample %0d arrived with nothing expected",
                                  sample_bus.sample));
      end else begin
        want = expected_samples.pop_front();
        if (sample_bus.sample !== want.sample)
          report_mismatch($sformatf("sample %0d: got %0d, expected %0d", samples_checked,
                                    sample_bus.sample, want.sample));
        if (sample_bus.block_end !== want.stop)
          report_mismatch($sformatf("sample %0d: block_end %b, expected %b", samples_checked,
                                    sample_bus.block_end, want.stop));
        if (sample_bus.block_loop !== want.loop)
          report_mismatch($sformatf("sample %0d: block_loop %b, expected %b", samples_checked,
                                    sample_bus.block_loop, want.loop));
        if (sample_bus.last !== want.second)
          report_mismatch($sformatf("sample %0d: last %b, expected %b", samples_checked,
                                    sample_bus.last, want.second));
        samples_checked++;
      end
    end
  end

endmodule
